### hdl/tkns_pkg.sv
package tkns_pkg;

    localparam int MAX_KEEP    = 16;
    localparam int INDEX_BITS  = 16;
    localparam int DIST_BITS   = 32;
    localparam int KEEP_BITS   = 5;
    localparam int RANK_BITS   = 4;
    localparam int KEEP_RESET  = 4;

    localparam int CNT_BITS    = $clog2(MAX_KEEP + 1);
    localparam int SLOT_BITS   = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;

    localparam int S_PAY_BITS  = INDEX_BITS + DIST_BITS;
    localparam int S_DATA_BITS = ((S_PAY_BITS + 7) / 8) * 8;
    localparam int M_PAY_BITS  = RANK_BITS + INDEX_BITS + DIST_BITS;
    localparam int M_DATA_BITS = ((M_PAY_BITS + 7) / 8) * 8;

    typedef struct packed {
        logic insert;
        logic emit_load;
    } tkns_cmd_t;

    typedef struct packed {
        logic out_valid;
        logic emit_final;
    } tkns_status_t;

    // Zero keeps one entry; anything above the list size keeps the full list.
    function automatic logic [CNT_BITS-1:0] effective_keep(input logic [KEEP_BITS-1:0] raw);
        int k;
        k = int'(raw);
        if (k == 0)
        begin
            k = 1;
        end
        if (k > MAX_KEEP)
        begin
            k = MAX_KEEP;
        end
        return CNT_BITS'(k);
    endfunction

endpackage

### hdl/tkns_ctrl.sv
module tkns_ctrl
    import tkns_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tlast,
    output logic         s_tready,
    input  logic         m_tready,
    input  tkns_status_t status,
    output tkns_cmd_t    cmd
);

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_DRAIN = 1'b1;

    logic state_reg;
    logic state_next;
    logic out_free;

    assign out_free = !status.out_valid || m_tready;

    always_comb
    begin
        state_next    = state_reg;
        s_tready      = 1'b0;
        cmd.insert    = 1'b0;
        cmd.emit_load = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready   = 1'b1;
                cmd.insert = s_tvalid;
                if (s_tvalid && s_tlast)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                // advance one entry into the output register whenever it frees up
                if (out_free)
                begin
                    cmd.emit_load = 1'b1;
                    if (status.emit_final)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### hdl/tkns_datapath.sv
module tkns_datapath
    import tkns_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [KEEP_BITS-1:0]   cfg_wr_data,
    input  logic [INDEX_BITS-1:0]  cand_index,
    input  logic [DIST_BITS-1:0]   cand_dist,
    input  logic                   m_tready,
    input  tkns_cmd_t              cmd,
    output tkns_status_t           status,
    output logic [RANK_BITS-1:0]   out_rank,
    output logic [INDEX_BITS-1:0]  out_index,
    output logic [DIST_BITS-1:0]   out_dist,
    output logic                   out_last,
    output logic                   out_valid
);

    logic [KEEP_BITS-1:0]  keep_reg;
    logic [CNT_BITS-1:0]   keep_eff;
    logic [CNT_BITS-1:0]   keep_m1;
    logic [CNT_BITS-1:0]   cnt_reg;
    logic [CNT_BITS-1:0]   cnt_next;
    logic [CNT_BITS-1:0]   cfg_keep;
    logic [RANK_BITS-1:0]  rank_reg;
    logic                  out_valid_reg;
    logic [RANK_BITS-1:0]  out_rank_reg;
    logic [INDEX_BITS-1:0] out_index_reg;
    logic [DIST_BITS-1:0]  out_dist_reg;
    logic                  out_last_reg;

    logic [INDEX_BITS-1:0] slot_index_reg [MAX_KEEP];
    logic [DIST_BITS-1:0]  slot_dist_reg  [MAX_KEEP];
    logic [MAX_KEEP-1:0]   goes_before;
    logic                  placed;
    logic                  full;
    logic                  emit_final;

    assign keep_eff   = effective_keep(keep_reg);
    assign keep_m1    = keep_eff - CNT_BITS'(1);
    assign cfg_keep   = effective_keep(cfg_wr_data);
    assign full       = (cnt_reg == keep_eff);
    assign emit_final = (cnt_reg == CNT_BITS'(1));

    // Each cell compares the candidate against its own entry; empty cells always lose.
    always_comb
    begin
        for (int i = 0; i < MAX_KEEP; i++)
        begin
            goes_before[i] = (CNT_BITS'(i) >= cnt_reg)
                          || (cand_dist < slot_dist_reg[i])
                          || ((cand_dist == slot_dist_reg[i])
                              && (cand_index < slot_index_reg[i]));
        end
    end

    assign placed = goes_before[keep_m1[SLOT_BITS-1:0]];

    always_ff @(posedge clk)
    begin
        if (cmd.insert && placed)
        begin
            for (int i = 0; i < MAX_KEEP; i++)
            begin
                if (goes_before[i])
                begin
                    if (i > 0 && goes_before[(i > 0) ? i - 1 : 0])
                    begin
                        slot_index_reg[i] <= slot_index_reg[(i > 0) ? i - 1 : 0];
                        slot_dist_reg[i]  <= slot_dist_reg[(i > 0) ? i - 1 : 0];
                    end
                    else
                    begin
                        slot_index_reg[i] <= cand_index;
                        slot_dist_reg[i]  <= cand_dist;
                    end
                end
            end
        end
        else if (cmd.emit_load)
        begin
            // shift the list toward the head so the next rank sits in cell zero
            for (int i = 0; i < MAX_KEEP - 1; i++)
            begin
                slot_index_reg[i] <= slot_index_reg[i + 1];
                slot_dist_reg[i]  <= slot_dist_reg[i + 1];
            end
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (cfg_wr_en)
        begin
            if (cnt_reg > cfg_keep)
            begin
                cnt_next = cfg_keep;
            end
        end
        else if (cmd.insert && !full)
        begin
            cnt_next = cnt_reg + CNT_BITS'(1);
        end
        else if (cmd.emit_load)
        begin
            cnt_next = cnt_reg - CNT_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keep_reg      <= KEEP_BITS'(KEEP_RESET);
            cnt_reg       <= '0;
            rank_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                keep_reg <= cfg_wr_data;
            end
            cnt_reg <= cnt_next;
            if (cmd.emit_load)
            begin
                rank_reg      <= emit_final ? '0 : rank_reg + RANK_BITS'(1);
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_load)
        begin
            out_rank_reg  <= rank_reg;
            out_index_reg <= slot_index_reg[0];
            out_dist_reg  <= slot_dist_reg[0];
            out_last_reg  <= emit_final;
        end
    end

    assign status.out_valid  = out_valid_reg;
    assign status.emit_final = emit_final;
    assign out_rank          = out_rank_reg;
    assign out_index         = out_index_reg;
    assign out_dist          = out_dist_reg;
    assign out_last          = out_last_reg;
    assign out_valid         = out_valid_reg;

    a_cnt_within_keep: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= keep_eff)
        else $error("held entry count exceeds keep count");

    a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_load |-> (cnt_reg != '0))
        else $error("emit from an empty list");

    a_emit_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_load |=> out_valid_reg)
        else $error("loaded entry not presented");

    a_rank_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_load && emit_final) |=> (rank_reg == '0))
        else $error("rank counter not cleared after list end");

endmodule

### hdl/top_k_nearest_select.sv
// Channel   Dir  Width  Contents (lowest bit up)
// s_axis    in   48     tdata: candidate_index[15:0], distance[31:0]; tlast: last_candidate
// m_axis    out  56     tdata: rank[3:0], neighbor_index[15:0], neighbor_distance[31:0],
//                       zero pad; tlast: list_end
// cfg       in   5      keep_count, written when cfg_wr_en is high
//
// A candidate enters the sorted list in the cycle of its transfer: one per cycle while idle.
// On a last candidate the list drains one entry per cycle through the free output register,
// and s_tready stays low until the final entry is loaded.
// The next candidate is taken while the final entry still waits in the output register.
// Reset clears the held count and sets keep_count to 4; held entries need no clearing.
// m_tready low holds the output register and stalls the drain.
module top_k_nearest_select
    import tkns_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [KEEP_BITS-1:0]   cfg_wr_data,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [S_DATA_BITS-1:0] s_tdata,   // candidate_index, distance
    input  logic                   s_tlast,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [M_DATA_BITS-1:0] m_tdata,   // rank, neighbor_index, neighbor_distance, pad
    output logic                   m_tlast
);

    tkns_cmd_t             cmd;
    tkns_status_t          status;
    logic [RANK_BITS-1:0]  out_rank;
    logic [INDEX_BITS-1:0] out_index;
    logic [DIST_BITS-1:0]  out_dist;

    tkns_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    tkns_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cand_index  (s_tdata[INDEX_BITS-1:0]),
        .cand_dist   (s_tdata[S_PAY_BITS-1:INDEX_BITS]),
        .m_tready    (m_tready),
        .cmd         (cmd),
        .status      (status),
        .out_rank    (out_rank),
        .out_index   (out_index),
        .out_dist    (out_dist),
        .out_last    (m_tlast),
        .out_valid   (m_tvalid)
    );

    assign m_tdata = M_DATA_BITS'({out_dist, out_index, out_rank});

endmodule

### bench/tkns_checker.sv
module tkns_checker
    import tkns_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [KEEP_BITS-1:0]   cfg_wr_data,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [S_DATA_BITS-1:0] s_tdata,
    input  logic                   s_tlast,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [M_DATA_BITS-1:0] m_tdata,
    input  logic                   m_tlast,
    output int                     mismatches,
    output int                     outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [RANK_BITS-1:0]  rank;
        logic [INDEX_BITS-1:0] index;
        logic [DIST_BITS-1:0]  distance;
        logic                  list_end;
    } neighbor_t;

    logic [KEEP_BITS-1:0]  keep_raw;
    logic [INDEX_BITS-1:0] kept_index [MAX_KEEP];
    logic [DIST_BITS-1:0]  kept_dist  [MAX_KEEP];
    int                    held;
    neighbor_t             neighbor_q [$];
    int                    errors;

    function automatic int keep_limit(input logic [KEEP_BITS-1:0] raw);
        int k;
        k = int'(raw);
        if (k < 1)
        begin
            k = 1;
        end
        else if (k > MAX_KEEP)
        begin
            k = MAX_KEEP;
        end
        return k;
    endfunction

    // Nearer distance wins; on equal distance the lower index wins.
    function automatic bit nearer(input logic [DIST_BITS-1:0] da, input logic [INDEX_BITS-1:0] ia,
                                  input logic [DIST_BITS-1:0] db, input logic [INDEX_BITS-1:0] ib);
        return (da < db) || (da == db && ia < ib);
    endfunction

    task automatic insert_candidate(input logic [INDEX_BITS-1:0] idx,
                                    input logic [DIST_BITS-1:0] cand_dist, input logic last);
        int        k;
        int        pos;
        bit        placed;
        neighbor_t nb;
        k = keep_limit(keep_raw);
        if (held > k)
        begin
            held = k;
        end
        if (held < k)
        begin
            pos = held;
            held++;
            placed = 1'b1;
        end
        else
        begin
            pos = held - 1;
            placed = nearer(cand_dist, idx, kept_dist[pos], kept_index[pos]);
        end
        if (placed)
        begin
            while (pos > 0 && nearer(cand_dist, idx, kept_dist[pos-1], kept_index[pos-1]))
            begin
                kept_dist[pos]  = kept_dist[pos-1];
                kept_index[pos] = kept_index[pos-1];
                pos--;
            end
            kept_dist[pos]  = cand_dist;
            kept_index[pos] = idx;
        end
        if (last)
        begin
            for (int r = 0; r < held; r++)
            begin
                nb.rank     = RANK_BITS'(r);
                nb.index    = kept_index[r];
                nb.distance = kept_dist[r];
                nb.list_end = (r + 1 == held);
                neighbor_q.push_back(nb);
            end
            held = 0;
        end
    endtask

    task automatic check_neighbor(input neighbor_t got);
        neighbor_t want;
        if (neighbor_q.size() == 0)
        begin
            errors++;
            if (errors <= 10)
            begin
                $display("%0t unexpected result: rank %0d index %h dist %h end %b",
                         $realtime, got.rank, got.index, got.distance, got.list_end);
            end
            return;
        end
        want = neighbor_q.pop_front();
        if (got.rank !== want.rank || got.index !== want.index
            || got.distance !== want.distance || got.list_end !== want.list_end)
        begin
            errors++;
            if (errors <= 10)
            begin
                $display("%0t mismatch: expected rank %0d index %h dist %h end %b",
                         $realtime, want.rank, want.index, want.distance, want.list_end);
                $display("%0t           actual   rank %0d index %h dist %h end %b",
                         $realtime, got.rank, got.index, got.distance, got.list_end);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keep_raw    = KEEP_BITS'(KEEP_RESET);
            held        = 0;
            errors      = 0;
            neighbor_q.delete();
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                keep_raw = cfg_wr_data;
                // a lower keep count drops the worst entries at once
                if (held > keep_limit(cfg_wr_data))
                begin
                    held = keep_limit(cfg_wr_data);
                end
            end
            if (s_tvalid && s_tready)
            begin
                insert_candidate(s_tdata[INDEX_BITS-1:0],
                                 s_tdata[INDEX_BITS +: DIST_BITS], s_tlast);
            end
            if (m_tvalid && m_tready)
            begin
                check_neighbor({m_tdata[RANK_BITS-1:0], m_tdata[RANK_BITS +: INDEX_BITS],
                                m_tdata[RANK_BITS+INDEX_BITS +: DIST_BITS], m_tlast});
            end
            mismatches  <= errors;
            outstanding <= neighbor_q.size();
        end
    end

endmodule

### bench/tb_top_k_nearest_select.sv
module tb_top_k_nearest_select;
    timeunit 1ns;
    timeprecision 1ps;
    import tkns_pkg::*;

    typedef enum int {DIST_ANY, DIST_NARROW, DIST_EXTREME, DIST_NEAR_BASE} dist_kind_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [KEEP_BITS-1:0]   cfg_wr_data = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_DATA_BITS-1:0] s_tdata = '0;   // candidate_index, distance
    logic                   s_tlast = 1'b0; // last_candidate
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_DATA_BITS-1:0] m_tdata;        // rank, neighbor_index, neighbor_distance, pad
    logic                   m_tlast;        // list_end

    int                     mismatches;
    int                     outstanding;
    bit                     quiet = 1'b0;
    int                     stall_left = 0;
    int                     sent = 0;
    logic [DIST_BITS-1:0]   dist_base;

    always #5 clk = ~clk;

    top_k_nearest_select uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    tkns_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // Receiver stalls come in bursts of random length.
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (!quiet && rst_n && $urandom_range(0, 5) == 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(0, 3);
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    task automatic send_candidate(input logic [INDEX_BITS-1:0] idx,
                                  input logic [DIST_BITS-1:0] dist_key, input logic last);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_DATA_BITS'({dist_key, idx});
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        sent++;
    endtask

    // Drop valid and let every expected neighbor come out before touching the register.
    task automatic settle();
        s_tvalid <= 1'b0;
        repeat (2) @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
    endtask

    task automatic write_keep(input logic [KEEP_BITS-1:0] value);
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [DIST_BITS-1:0] pick_dist();
        dist_kind_t kind;
        kind = dist_kind_t'($urandom_range(0, 3));
        case (kind)
            DIST_ANY:       return DIST_BITS'($urandom());
            DIST_NARROW:    return DIST_BITS'($urandom_range(0, 15));
            DIST_EXTREME:   return $urandom_range(0, 1) ? '1 : '0;
            default:        return dist_base + DIST_BITS'($urandom_range(0, 63));
        endcase
    endfunction

    function automatic logic [INDEX_BITS-1:0] pick_index();
        if ($urandom_range(0, 3) == 0)
        begin
            return INDEX_BITS'($urandom_range(0, 7));
        end
        return INDEX_BITS'($urandom());
    endfunction

    task automatic send_set(input int count, input bit finish);
        logic [INDEX_BITS-1:0] idx;
        logic [DIST_BITS-1:0]  dist_key;
        dist_base = DIST_BITS'($urandom());
        for (int i = 0; i < count; i++)
        begin
            idx      = pick_index();
            dist_key = pick_dist();
            send_candidate(idx, dist_key, finish && (i == count - 1));
            // repeat a candidate now and then: an identical entry is never strictly better
            if ($urandom_range(0, 15) == 0 && i < count - 1)
            begin
                send_candidate(idx, dist_key, 1'b0);
            end
        end
    endtask

    initial
    begin
        int                   keep_plan [9];
        logic [KEEP_BITS-1:0] keep;
        int                   k;
        int                   phase;

        keep_plan = '{1, 16, 7, 0, 31, 2, 5, 17, 3};
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // fewer than the reset keep count; equal distances fall back to the index
        send_candidate(16'hFFFF, 32'hFFFF_FFFF, 1'b0);
        send_candidate(16'h0000, 32'h0000_0000, 1'b0);
        send_candidate(16'h1234, 32'hFFFF_FFFF, 1'b1);
        // a set of one
        send_candidate(16'h8000, 32'h8000_0000, 1'b1);
        // full list: worse and identical candidates drop, a better one moves up
        send_candidate(16'd10, 32'd100, 1'b0);
        send_candidate(16'd11, 32'd50,  1'b0);
        send_candidate(16'd12, 32'd100, 1'b0);
        send_candidate(16'd9,  32'd100, 1'b0);
        send_candidate(16'd13, 32'd100, 1'b0);
        send_candidate(16'd12, 32'd100, 1'b0);
        send_candidate(16'd5,  32'd100, 1'b1);
        // keep count zero acts as one
        write_keep(KEEP_BITS'(0));
        send_candidate(16'h00FF, 32'h0000_0010, 1'b0);
        send_candidate(16'h0100, 32'h0000_0008, 1'b0);
        send_candidate(16'h0001, 32'h0000_0010, 1'b1);
        // saturate to the full list, then shrink with entries held
        write_keep(KEEP_BITS'(31));
        send_candidate(16'h0AAA, 32'h5555_5555, 1'b0);
        send_candidate(16'h5555, 32'hAAAA_AAAA, 1'b0);
        send_candidate(16'h0003, 32'h0000_0003, 1'b0);
        send_candidate(16'h0004, 32'h0000_0003, 1'b0);
        send_candidate(16'hFFFE, 32'hFFFF_FFFE, 1'b0);
        write_keep(KEEP_BITS'(2));
        send_candidate(16'h0002, 32'h0000_0004, 1'b1);

        phase = 0;
        while (sent < 340)
        begin
            keep = (phase < 9) ? KEEP_BITS'(keep_plan[phase])
                               : KEEP_BITS'($urandom_range(0, 31));
            write_keep(keep);
            k = (keep == 0) ? 1 : ((keep > MAX_KEEP) ? MAX_KEEP : int'(keep));
            repeat ($urandom_range(2, 4))
            begin
                if ($urandom_range(0, 7) == 0)
                begin
                    send_set($urandom_range(1, 24), 1'b1);
                end
                else
                begin
                    send_set($urandom_range(1, 2 * k + 3), 1'b1);
                end
            end
            // leave a partial set held across the next register write
            if ($urandom_range(0, 3) == 0)
            begin
                send_set($urandom_range(1, 8), 1'b0);
            end
            phase++;
        end

        write_keep(KEEP_BITS'(MAX_KEEP));
        quiet = 1'b1;
        while (sent < 400)
        begin
            send_set($urandom_range(4, 20), 1'b1);
        end

        settle();
        if (mismatches == 0 && outstanding == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial
    begin
        #2ms;
        $display("== FAIL ==");
        $finish;
    end

endmodule
